@@ design/bale_pkg.sv @@
// Shared types and constants for the bounded array list engine.
// Request and result payloads, status and request codes, controller links.
// No dependencies.
`default_nettype none

package bale_pkg;

    // List storage
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths fixed by the interface
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int CAP_W = 7;
    localparam int ENT_W = 7;

    // Width wide enough to compare positions, counts and capacity
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CAP_W-1:0]        CAP_RST = 7'd64;
    localparam logic signed [VAL_W-1:0] RD_FAIL = '1;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef struct packed {
        t_req                      req_type;
        logic [POS_W-1:0]          position;
        logic signed [VAL_W-1:0]   new_value;
    } t_in_req;

    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   read_value;
        logic [ENT_W-1:0]          entry_count;
        logic                      is_full;
        logic                      is_empty;
    } t_out_res;

    // Controller to datapath
    typedef struct packed {
        logic load;         // capture the request
        logic shift_start;  // first read of a shift sweep
        logic shift_step;   // write one moved entry, read the next
        logic put;          // write the new value at the position
        logic rd_issue;     // read the entry at the position
        logic finish;       // update count and load the result
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        t_status chk;         // outcome of the checks on the held request
        t_req    req;         // held request type
        logic    shift_need;  // entries must move
        logic    shift_more;  // further reads remain in the sweep
        logic    out_free;    // result register can take a result
    } t_ctl_sts;

endpackage

`default_nettype wire

@@ design/bounded_array_list_engine.sv @@
// Bounded ordered list engine: top level joining sequencer and datapath.
// Depends on bale_pkg, bale_ctrl, bale_dp.
//
// Keeps an ordered list of signed 32-bit values in a DEPTH-entry RAM and
// handles one request at a time: insert, remove, read or clear, each giving
// one result with status, read value, entry count and full/empty flags.
// Insert and remove move later entries one RAM location per cycle through
// the single write port, and no request can finish while the result
// register is held by a stalled output. The store needs no clearing pass
// after reset. The user must write capacity only while no request is in
// flight; the block itself does not enforce it.
`default_nettype none

module bounded_array_list_engine import bale_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire t_in_req          i_in_req,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_res              o_out_res,
    input  wire logic             i_out_stall,
    input  wire logic             i_cfg_valid,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // Capacity writes are always taken
    assign o_cfg_ready = 1'b1;

    bale_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bale_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_req    (i_in_req),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

@@ design/bale_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Read data holds while no read is enabled. No dependencies.
`default_nettype none

module bale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/bale_ctrl.sv @@
// Request sequencer for the list engine: decodes, runs shift sweeps, finishes.
// Depends on bale_pkg.
`default_nettype none

module bale_ctrl import bale_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // New requests only enter from idle
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.chk != ST_OK) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_sts.req)
                        REQ_INSERT: begin
                            if (i_sts.shift_need) begin
                                o_cmd.shift_start = 1'b1;
                                n_state           = S_SHIFT;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        REQ_REMOVE: begin
                            if (i_sts.shift_need) begin
                                o_cmd.shift_start = 1'b1;
                                n_state           = S_SHIFT;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        REQ_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_DONE;
                        end
                        REQ_CLEAR: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (!i_sts.shift_more) begin
                    n_state = (i_sts.req == REQ_INSERT) ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    // Only insert and remove ever sweep the store
    a_shift_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (i_sts.req == REQ_INSERT || i_sts.req == REQ_REMOVE))
        else $error("shift sweep for a request that does not move entries");

    // A sweep is only entered with entries to move
    a_shift_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.shift_start |-> (i_sts.chk == ST_OK && i_sts.shift_need))
        else $error("shift started on a failed request");

    // Every accepted request reaches a result before the next is taken
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE))
        else $error("finish did not return to idle");
`endif

endmodule

`default_nettype wire

@@ design/bale_dp.sv @@
// Datapath for the list engine: request hold, count, capacity, store, result.
// Depends on bale_pkg and bale_ram.
`default_nettype none

module bale_dp import bale_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_ctl_cmd         i_cmd,
    output t_ctl_sts              o_sts,
    input  wire t_in_req          i_in_req,
    input  wire logic             i_cfg_wr,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    output t_out_res              o_out_res,
    input  wire logic             i_out_stall
);

    // Held request
    t_req               r_req;
    logic [POS_W-1:0]   r_pos;
    logic [VAL_W-1:0]   r_val;

    // List state and configuration
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CAP_W-1:0]   r_cap;

    // Shift sweep pointers
    logic [ADDR_W-1:0]  r_ptr;
    logic [ADDR_W-1:0]  r_wptr;
    logic [ADDR_W-1:0]  r_left;

    // Result register
    t_out_res           r_out;
    logic               r_out_valid;

    logic [CMP_W-1:0]   cnt_x;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   cap_x;
    logic [CMP_W-1:0]   first_rd;
    logic [CMP_W-1:0]   first_wr;
    logic [CMP_W-1:0]   next_ptr;
    logic [CMP_W-1:0]   left_x;
    logic               is_ins;
    t_status            chk;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VAL_W-1:0]   ram_rdata;

    assign cnt_x  = CMP_W'(r_count);
    assign pos_x  = CMP_W'(r_pos);
    assign is_ins = (r_req == REQ_INSERT);

    // Effective capacity, clamped to 1..DEPTH
    always_comb begin
        if (r_cap == '0) begin
            cap_x = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(DEPTH)) begin
            cap_x = CMP_W'(DEPTH);
        end else begin
            cap_x = CMP_W'(r_cap);
        end
    end

    // Request checks; insert looks at the index before fullness
    always_comb begin
        chk = ST_OK;
        unique case (r_req)
            REQ_INSERT: begin
                if (pos_x > cnt_x) begin
                    chk = ST_INVALID;
                end else if (cnt_x >= cap_x) begin
                    chk = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                if (cnt_x == '0) begin
                    chk = ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    chk = ST_INVALID;
                end
            end
            REQ_READ: begin
                if (pos_x >= cnt_x) begin
                    chk = ST_INVALID;
                end
            end
            REQ_CLEAR: begin
                chk = ST_OK;
            end
        endcase
    end

    // Sweep start: insert moves down from the tail, remove moves up from pos
    always_comb begin
        if (is_ins) begin
            first_rd = cnt_x - CMP_W'(1);
            first_wr = cnt_x;
            next_ptr = cnt_x - CMP_W'(2);
            left_x   = cnt_x - pos_x - CMP_W'(1);
        end else begin
            first_rd = pos_x + CMP_W'(1);
            first_wr = pos_x;
            next_ptr = pos_x + CMP_W'(2);
            left_x   = cnt_x - pos_x - CMP_W'(2);
        end
    end

    assign o_sts.chk        = chk;
    assign o_sts.req        = r_req;
    assign o_sts.shift_need = is_ins ? (pos_x != cnt_x) : ((pos_x + CMP_W'(1)) != cnt_x);
    assign o_sts.shift_more = (r_left != '0);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    // Store port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wptr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_ptr;
        if (i_cmd.shift_start) begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(first_rd);
        end
        if (i_cmd.shift_step) begin
            ram_we = 1'b1;
            ram_re = (r_left != '0);
        end
        if (i_cmd.put) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(r_pos);
            ram_wdata = r_val;
        end
        if (i_cmd.rd_issue) begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(r_pos);
        end
    end

    bale_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Count after the request
    always_comb begin
        n_count = r_count;
        unique case (r_req)
            REQ_INSERT: begin
                if (chk == ST_OK) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_REMOVE: begin
                if (chk == ST_OK) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            REQ_READ: begin
                n_count = r_count;
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
        endcase
    end

    // Request hold and sweep pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_req.req_type;
            r_pos <= i_in_req.position;
            r_val <= i_in_req.new_value;
        end
        if (i_cmd.shift_start) begin
            r_wptr <= ADDR_W'(first_wr);
            r_ptr  <= ADDR_W'(next_ptr);
            r_left <= ADDR_W'(left_x);
        end else if (i_cmd.shift_step && (r_left != '0)) begin
            r_wptr <= is_ins ? (r_ptr + ADDR_W'(1)) : (r_ptr - ADDR_W'(1));
            r_ptr  <= is_ins ? (r_ptr - ADDR_W'(1)) : (r_ptr + ADDR_W'(1));
            r_left <= r_left - ADDR_W'(1);
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.status      <= chk;
            r_out.entry_count <= ENT_W'(n_count);
            r_out.is_full     <= (CMP_W'(n_count) >= cap_x);
            r_out.is_empty    <= (n_count == '0);
            if (r_req == REQ_READ) begin
                r_out.read_value <= (chk == ST_OK) ? ram_rdata : RD_FAIL;
            end else begin
                r_out.read_value <= '0;
            end
        end
    end

    // Count, capacity and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

`ifndef SYNTH
    // The count never runs past the store
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(DEPTH))
        else $error("entry count beyond store depth");

    // Count moves only when a result is produced
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> $stable(r_count))
        else $error("entry count changed outside finish");

    // A sweep never writes the entry it reads in the same cycle
    a_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("store read and write at the same address");
`endif

endmodule

`default_nettype wire
